[hdl/sitda_pkg.sv]
`timescale 1ns / 1ps
// shared constants for the signed integer to decimal ascii converter
package sitda_pkg;

    localparam int VALUE_WIDTH = 32;
    // decimal digits needed for a magnitude of up to 2^(VALUE_WIDTH-1)
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    typedef logic [3:0] bcd_digit_t;

endpackage

[hdl/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// signed integer to decimal ascii converter, top level
//
// Takes one signed two's complement value and returns its decimal text, one
// ASCII character per output transfer, most significant digit first, with a
// leading minus sign for negative values and last_char set on the final
// character. The magnitude is turned into packed BCD by a shift-and-add-3
// unit that handles one input bit per cycle; leading zero digits are then
// dropped one per cycle, and the characters are sent one per cycle while the
// output accepts them. in_ready is high only between values; the final
// character may still sit in the output register while the next value is
// taken.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic        [7:0]             character,
    output logic                          last_char
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             state_reg,     state_next;
    logic                   neg_reg,       neg_next;
    logic [VALUE_WIDTH-1:0] mag_reg,       mag_next;
    logic [BCD_WIDTH-1:0]   bcd_reg,       bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg,   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg,   dig_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             char_reg,      char_next;
    logic                   last_reg,      last_next;

    logic [VALUE_WIDTH-1:0] value_u;
    logic [VALUE_WIDTH-1:0] value_abs;
    logic [BCD_WIDTH-1:0]   bcd_adj;
    bcd_digit_t             top_digit;
    logic                   out_free;
    logic                   dig_last;

    assign value_u   = VALUE_WIDTH'(value);
    assign value_abs = value_u[VALUE_WIDTH-1]
                       ? VALUE_WIDTH'(~value_u + VALUE_WIDTH'(1)) : value_u;
    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];
    assign out_free  = !out_valid_reg || out_ready;
    assign dig_last  = (dig_cnt_reg == DIG_CNT_W'(1));

    // add 3 to every digit of 5 or more ahead of the shift
    always_comb
    begin
        bcd_digit_t d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? bcd_digit_t'(d + 4'd3) : d;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next     = value_u[VALUE_WIDTH-1];
                    mag_next     = value_abs;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_WIDTH-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros but always keep the units digit
                if (top_digit == 4'd0 && !dig_last)
                begin
                    bcd_next     = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {4'd0, top_digit};
                    last_next      = dig_last;
                    bcd_next       = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
                    dig_cnt_next   = dig_cnt_reg - DIG_CNT_W'(1);
                    if (dig_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

`ifndef SYNTHESIS
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == CHAR_MINUS ||
                       (character >= CHAR_ZERO && character <= CHAR_NINE)))
        else $error("character is neither a digit nor a minus sign");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && character == CHAR_MINUS) |-> !last_char)
        else $error("minus sign marked as last character");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_SIGN || state_reg == ST_EMIT)
            |-> dig_cnt_reg != '0)
        else $error("digit count ran out before the units digit");

    a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && bit_cnt_reg == BIT_CNT_W'(1))
            |=> state_reg == ST_SKIP && dig_cnt_reg == DIG_CNT_W'(NUM_DIGITS))
        else $error("conversion did not hand over a full digit field");
`endif

endmodule

[tb/tb_signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// self-checking testbench for the signed integer to decimal ascii converter
module tb_signed_int_to_decimal_ascii;
    import sitda_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int GAP_PERCENT   = 17;
    localparam int QUIET_FROM    = 6000;
    localparam int QUIET_TO      = 11000;
    localparam int RANDOM_ITEMS  = 430;
    localparam int DRAIN_CYCLES  = 60;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } text_char_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic signed [VALUE_WIDTH-1:0] value     = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic        [7:0]             character;
    logic                          last_char;

    logic signed [VALUE_WIDTH-1:0] values_to_send[$];
    text_char_t                    pending_chars[$];
    int                            fail_count  = 0;
    int                            cycle_count = 0;

    signed_int_to_decimal_ascii DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last_char (last_char)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // random gaps, except in one quiet stretch of the run
    function automatic bit take_gap();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < GAP_PERCENT;
    endfunction

    // expected decimal text of one value, sign first, most significant digit next
    function automatic void spell_value(logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] magnitude;
        bcd_digit_t             digit_list[$];
        text_char_t             entry;
        magnitude = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
        while (magnitude != 0)
        begin
            digit_list.push_front(bcd_digit_t'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        if (digit_list.size() == 0)
            digit_list.push_back(bcd_digit_t'(0));
        if (v[VALUE_WIDTH-1])
        begin
            entry.character = CHAR_MINUS;
            entry.last_char = 1'b0;
            pending_chars.push_back(entry);
        end
        foreach (digit_list[i])
        begin
            entry.character = CHAR_ZERO + 8'(digit_list[i]);
            entry.last_char = (i == digit_list.size() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    // values shaped by digit count most often, plus raw bit patterns and edge regions
    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        int          kind;
        int          ndigits;
        longint      lo;
        longint      hi;
        longint      pick;
        logic [31:0] r;
        kind = $urandom_range(9);
        r    = $urandom;
        pick = 0;
        case (kind)
            0, 1, 2:
                return r;
            3, 4, 5, 6:
            begin
                ndigits = $urandom_range(1, 10);
                lo = 1;
                repeat (ndigits - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (ndigits == 1)
                    lo = 0;
                if (hi > 64'sd2147483647)
                    hi = 64'sd2147483647;
                pick = lo + (longint'(r) % (hi - lo + 1));
            end
            7:
                pick = $urandom_range(20);
            8:
                if (r[31])
                    return 32'h7FFF_FFFF - r[3:0];
                else
                    return 32'h8000_0000 + r[3:0];
            default:
            begin
                pick = 1;
                repeat ($urandom_range(9)) pick = pick * 10;
                pick = pick + $signed($urandom_range(2)) - 1;
            end
        endcase
        if ($urandom_range(1))
            pick = -pick;
        return pick[31:0];
    endfunction

    // input side: one transfer per accepted value, gaps only between values
    always @(posedge clk)
    begin : drive_values
        logic load_next;
        if (rst_n)
        begin
            load_next = !in_valid;
            if (in_valid && in_ready)
            begin
                spell_value(value);
                load_next = 1'b1;
            end
            if (load_next)
            begin
                if (values_to_send.size() != 0 && !take_gap())
                begin
                    value    <= values_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: compare each transfer with the oldest expected character
    always @(posedge clk)
    begin : check_chars
        text_char_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character %0d, last_char %0b", character, last_char);
                    fail_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (character !== want.character)
                    begin
                        $error("character: expected %0d, actual %0d",
                               want.character, character);
                        fail_count++;
                    end
                    if (last_char !== want.last_char)
                    begin
                        $error("last_char: expected %0b, actual %0b",
                               want.last_char, last_char);
                        fail_count++;
                    end
                end
            end
            out_ready <= !take_gap();
        end
    end

    initial
    begin
        values_to_send = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
            32'sd99, 32'sd100, -32'sd100, 32'sd101, 32'sd1000000000,
            32'sd999999999, -32'sd1000000000, -32'sd999999999,
            32'sd2147483647, 32'sd2147483646, -32'sd2147483647,
            32'sh8000_0000, 32'sh8000_0001, 32'sd1000000001, -32'sd5, 32'sd7
        };
        repeat (RANDOM_ITEMS) values_to_send.push_back(random_value());

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // all values taken, then all characters back, then a quiet tail
        @(posedge clk);
        while (values_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
